// ===== sv/multitouch_event_tracker_macros.svh =====
// Assertion macros used by the multitouch event tracker checker.
`ifndef MULTITOUCH_EVENT_TRACKER_MACROS_SVH
`define MULTITOUCH_EVENT_TRACKER_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define MTET_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Same check with an implication written out by the macro.
`define MTET_ASSERT_IMP(label, cond, prop, msg) \
   `MTET_ASSERT(label, (cond) |-> (prop), msg)

`endif

// ===== sv/mtet_pkg.sv =====
// Types, constants and codes of the multitouch event tracker.
package mtet_pkg;

   localparam int MAX_POINTS     = 8;
   localparam int COORD_BITS     = 12;
   localparam int TABLE_DEPTH    = 8;
   localparam int ID_BITS        = 4;
   localparam int SLOT_BITS      = 3;
   localparam int FIELD_BITS     = 12;
   localparam int PRESSURE_BITS  = 8;
   localparam int LAYER_BITS     = 4;
   localparam int STORE_BITS     = (COORD_BITS < FIELD_BITS) ? COORD_BITS : FIELD_BITS;
   localparam int COUNT_BITS     = $clog2(MAX_POINTS + 1);
   localparam int WALK_BITS      = $clog2(TABLE_DEPTH);
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 8;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_THRESHOLD = 1'b0,
      CSR_LAYER     = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_UP   = 2'd0,
      KIND_DOWN = 2'd1,
      KIND_MOVE = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPS,
      ST_PTS,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic [ID_BITS-1:0]    id;
      logic [STORE_BITS-1:0] x;
      logic [STORE_BITS-1:0] y;
   } point_type;

   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctrl_type;

   typedef struct packed {
      kind_type              kind;
      logic [ID_BITS-1:0]    id;
      logic [STORE_BITS-1:0] x;
      logic [STORE_BITS-1:0] y;
   } event_type;

endpackage

// ===== sv/mtet_point_cell.sv =====
// One cell of the frame point chain: holds a kept point, shifts toward the head.
module mtet_point_cell (
   input  logic                   clock,
   input  mtet_pkg::cell_ctrl_type ctrl,
   input  mtet_pkg::point_type    load_point,
   input  mtet_pkg::point_type    next_point,
   output mtet_pkg::point_type    point
);

   mtet_pkg::point_type point_ff;
   mtet_pkg::point_type point_in;

   always_comb begin
      point_in = point_ff;
      if (ctrl.shift) begin
         point_in = next_point;
      end else if (ctrl.load) begin
         point_in = load_point;
      end
   end

   always_ff @(posedge clock) begin
      point_ff <= point_in;
   end

   assign point = point_ff;

endmodule

// ===== sv/mtet_table_cell.sv =====
// One cell of the active identifier table: rotates with its neighbor, zero means free.
module mtet_table_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  mtet_pkg::cell_ctrl_type       ctrl,
   input  logic [mtet_pkg::ID_BITS-1:0]  load_id,
   input  logic [mtet_pkg::ID_BITS-1:0]  next_id,
   output logic [mtet_pkg::ID_BITS-1:0]  id
);

   logic [mtet_pkg::ID_BITS-1:0] id_ff;
   logic [mtet_pkg::ID_BITS-1:0] id_in;

   always_comb begin
      id_in = id_ff;
      if (ctrl.shift) begin
         id_in = next_id;
      end else if (ctrl.load) begin
         id_in = load_id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         id_ff <= '0;
      end else begin
         id_ff <= id_in;
      end
   end

   assign id = id_ff;

endmodule

// ===== sv/multitouch_event_tracker.sv =====
// Multitouch event tracker: point readings are accepted one per cycle while a frame is
// open. The item that closes a frame starts an event pass: the identifier table chain
// rotates once through its 8 cells (one UP per absent identifier), then the point chain
// shifts out one kept point per cycle while the output can take it (MOVE or DOWN), and
// once the chain is empty the flush state drains the last event, so req_ready stays low
// from a closing transaction until the pass is done, also while rsp_ready is low. One
// event is delivered per transaction on the rsp side.
module multitouch_event_tracker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_present,
   input  logic [mtet_pkg::SLOT_BITS-1:0]      req_slot,
   input  logic [mtet_pkg::FIELD_BITS-1:0]     req_pos_x,
   input  logic [mtet_pkg::FIELD_BITS-1:0]     req_pos_y,
   input  logic [mtet_pkg::PRESSURE_BITS-1:0]  req_pressure,
   input  logic                                req_frame_end,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_event_kind,
   output logic [mtet_pkg::ID_BITS-1:0]        rsp_touch_id,
   output logic [mtet_pkg::FIELD_BITS-1:0]     rsp_out_x,
   output logic [mtet_pkg::FIELD_BITS-1:0]     rsp_out_y,
   output logic [mtet_pkg::LAYER_BITS-1:0]     rsp_layer,
   output logic                                rsp_last_of_run,
   input  logic                                csr_we,
   input  logic [mtet_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [mtet_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int NP = mtet_pkg::MAX_POINTS;
   localparam int NT = mtet_pkg::TABLE_DEPTH;

   // configuration
   logic [mtet_pkg::PRESSURE_BITS-1:0] threshold_ff;
   logic [mtet_pkg::LAYER_BITS-1:0]    layer_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
         layer_ff     <= '0;
      end else if (csr_we) begin
         case (mtet_pkg::csr_index_type'(csr_index))
            mtet_pkg::CSR_THRESHOLD: threshold_ff <= csr_wdata;
            mtet_pkg::CSR_LAYER:     layer_ff     <= csr_wdata[mtet_pkg::LAYER_BITS-1:0];
            default: ;
         endcase
      end
   end

   // control state
   mtet_pkg::state_type              state_ff, state_in;
   logic [mtet_pkg::COUNT_BITS-1:0]  count_ff, count_in;
   logic [mtet_pkg::WALK_BITS-1:0]   walk_ff, walk_in;
   mtet_pkg::event_type              hold_ff, hold_in;
   logic                             hold_valid_ff, hold_valid_in;
   mtet_pkg::event_type              rsp_event_ff, rsp_event_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_last_ff, rsp_last_in;
   logic [mtet_pkg::LAYER_BITS-1:0]  rsp_layer_ff, rsp_layer_in;

   // cell chains
   mtet_pkg::point_type            pt [NP];
   mtet_pkg::point_type            pt_next [NP];
   mtet_pkg::cell_ctrl_type        pt_ctrl [NP];
   logic [mtet_pkg::ID_BITS-1:0]   tbl [NT];
   logic [mtet_pkg::ID_BITS-1:0]   tbl_next [NT];
   mtet_pkg::cell_ctrl_type        tbl_ctrl [NT];

   logic [NP-1:0]                  occupied;
   logic [NP-1:0]                  pt_match;
   logic [NT-1:0]                  free_onehot;
   logic                           match_any;
   logic                           in_frame;
   logic                           head_active;
   logic                           kept;
   logic                           up_hit;
   logic                           out_free;
   logic                           can_push;
   mtet_pkg::point_type            new_point;
   logic [mtet_pkg::ID_BITS-1:0]   req_id;

   // sequencer outputs
   logic                           accept;
   logic                           up_step;
   logic                           pt_step;
   logic                           emit;
   logic                           out_load;
   logic                           out_last;
   mtet_pkg::event_type            new_event;

   assign req_id      = mtet_pkg::ID_BITS'(req_slot) + mtet_pkg::ID_BITS'(1);
   assign kept        = req_present && (req_pressure > threshold_ff);
   assign new_point.id = req_id;
   assign new_point.x  = req_pos_x[mtet_pkg::STORE_BITS-1:0];
   assign new_point.y  = req_pos_y[mtet_pkg::STORE_BITS-1:0];
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign can_push    = !hold_valid_ff || out_free;

   always_comb begin
      match_any   = 1'b0;
      in_frame    = 1'b0;
      head_active = 1'b0;
      for (int i = 0; i < NP; i++) begin
         occupied[i] = mtet_pkg::COUNT_BITS'(i) < count_ff;
         pt_match[i] = occupied[i] && (pt[i].id == req_id);
         match_any   = match_any || pt_match[i];
         in_frame    = in_frame || (occupied[i] && (pt[i].id == tbl[0]));
      end
      for (int i = 0; i < NT; i++) begin
         head_active = head_active || (tbl[i] == pt[0].id);
      end
   end

   always_comb begin
      logic found;
      found = 1'b0;
      for (int i = 0; i < NT; i++) begin
         free_onehot[i] = (tbl[i] == '0) && !found;
         found          = found || (tbl[i] == '0);
      end
   end

   assign up_hit = (tbl[0] != '0) && !in_frame;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mtet_pkg::ST_IDLE: begin
            if (req_valid && req_frame_end) begin
               state_in = mtet_pkg::ST_UPS;
            end
         end
         mtet_pkg::ST_UPS: begin
            if (up_step && (walk_ff == mtet_pkg::WALK_BITS'(NT - 1))) begin
               state_in = mtet_pkg::ST_PTS;
            end
         end
         mtet_pkg::ST_PTS: begin
            if (count_ff == '0) begin
               state_in = mtet_pkg::ST_FLUSH;
            end
         end
         mtet_pkg::ST_FLUSH: begin
            if (!hold_valid_ff || out_free) begin
               state_in = mtet_pkg::ST_IDLE;
            end
         end
         default: state_in = mtet_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      accept    = 1'b0;
      up_step   = 1'b0;
      pt_step   = 1'b0;
      emit      = 1'b0;
      out_load  = 1'b0;
      out_last  = 1'b0;
      new_event = '{kind: mtet_pkg::KIND_UP, id: tbl[0], x: '0, y: '0};
      case (state_ff)
         mtet_pkg::ST_IDLE: begin
            accept = req_valid;
         end
         mtet_pkg::ST_UPS: begin
            up_step = !up_hit || can_push;
            emit    = up_hit && can_push;
         end
         mtet_pkg::ST_PTS: begin
            pt_step   = (count_ff != '0) && can_push;
            emit      = pt_step;
            new_event = '{kind: head_active ? mtet_pkg::KIND_MOVE : mtet_pkg::KIND_DOWN,
                          id: pt[0].id, x: pt[0].x, y: pt[0].y};
         end
         mtet_pkg::ST_FLUSH: begin
            out_load = hold_valid_ff && out_free;
            out_last = 1'b1;
         end
         default: ;
      endcase
      if (emit && hold_valid_ff) begin
         out_load = 1'b1;
      end
   end

   assign req_ready = (state_ff == mtet_pkg::ST_IDLE);

   always_comb begin
      count_in      = count_ff;
      walk_in       = walk_ff;
      hold_in       = hold_ff;
      hold_valid_in = hold_valid_ff;
      rsp_event_in  = rsp_event_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_layer_in  = rsp_layer_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      if (accept && kept && !match_any && (count_ff < mtet_pkg::COUNT_BITS'(NP))) begin
         count_in = count_ff + mtet_pkg::COUNT_BITS'(1);
      end
      if (pt_step) begin
         count_in = count_ff - mtet_pkg::COUNT_BITS'(1);
      end
      if (state_ff == mtet_pkg::ST_IDLE) begin
         walk_in = '0;
      end else if (up_step) begin
         walk_in = walk_ff + mtet_pkg::WALK_BITS'(1);
      end
      if (out_load) begin
         rsp_event_in  = hold_ff;
         rsp_last_in   = out_last;
         rsp_layer_in  = layer_ff;
         rsp_valid_in  = 1'b1;
         hold_valid_in = 1'b0;
      end
      if (emit) begin
         hold_in       = new_event;
         hold_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mtet_pkg::ST_IDLE;
         count_ff      <= '0;
         walk_ff       <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         walk_ff       <= walk_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff      <= hold_in;
      rsp_event_ff <= rsp_event_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_layer_ff <= rsp_layer_in;
   end

   // point chain
   for (genvar i = 0; i < NP; i++) begin : g_point
      if (i == NP - 1) begin : g_tail
         assign pt_next[i] = '0;
      end else begin : g_body
         assign pt_next[i] = pt[i+1];
      end
      assign pt_ctrl[i].shift = pt_step;
      assign pt_ctrl[i].load  = accept && kept &&
                                (match_any ? pt_match[i]
                                           : (count_ff == mtet_pkg::COUNT_BITS'(i)));
      mtet_point_cell u_cell (
         .clock      (clock),
         .ctrl       (pt_ctrl[i]),
         .load_point (new_point),
         .next_point (pt_next[i]),
         .point      (pt[i])
      );
   end

   // identifier table chain
   for (genvar i = 0; i < NT; i++) begin : g_table
      if (i == NT - 1) begin : g_tail
         assign tbl_next[i] = up_hit ? '0 : tbl[0];
      end else begin : g_body
         assign tbl_next[i] = tbl[i+1];
      end
      assign tbl_ctrl[i].shift = up_step;
      assign tbl_ctrl[i].load  = pt_step && !head_active && free_onehot[i];
      mtet_table_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctrl    (tbl_ctrl[i]),
         .load_id (pt[0].id),
         .next_id (tbl_next[i]),
         .id      (tbl[i])
      );
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_kind  = rsp_event_ff.kind;
   assign rsp_touch_id    = rsp_event_ff.id;
   assign rsp_out_x       = mtet_pkg::FIELD_BITS'(rsp_event_ff.x);
   assign rsp_out_y       = mtet_pkg::FIELD_BITS'(rsp_event_ff.y);
   assign rsp_layer       = rsp_layer_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule

// ===== sv/multitouch_event_tracker_checker.sv =====
// Port-level assertions for the multitouch event tracker, bound to the top level.
`include "multitouch_event_tracker_macros.svh"

module multitouch_event_tracker_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [1:0]                        rsp_event_kind,
   input logic [mtet_pkg::ID_BITS-1:0]      rsp_touch_id,
   input logic [mtet_pkg::FIELD_BITS-1:0]   rsp_out_x,
   input logic [mtet_pkg::FIELD_BITS-1:0]   rsp_out_y,
   input logic [mtet_pkg::LAYER_BITS-1:0]   rsp_layer,
   input logic                              rsp_last_of_run
);

   // stalled result transaction holds its payload
   `MTET_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_kind) && $stable(rsp_touch_id) && $stable(rsp_out_x) && $stable(rsp_out_y) && $stable(rsp_layer) && $stable(rsp_last_of_run), "rsp payload changed while stalled")

   `MTET_ASSERT_IMP(a_up_zero, rsp_valid && (rsp_event_kind == mtet_pkg::KIND_UP), (rsp_out_x == '0) && (rsp_out_y == '0), "up event with nonzero coordinates")

   `MTET_ASSERT_IMP(a_id_range, rsp_valid, (rsp_touch_id != '0) && (rsp_touch_id <= mtet_pkg::ID_BITS'(mtet_pkg::TABLE_DEPTH)) && (rsp_event_kind != 2'd3), "bad touch id or event kind")

   // a frame's events are not interleaved with new input
   `MTET_ASSERT_IMP(a_run_busy, rsp_valid && !rsp_last_of_run, !req_ready, "input taken inside an event run")

endmodule

bind multitouch_event_tracker multitouch_event_tracker_checker u_checker (.*);
